### design/dsrp_pkg.sv
// Package for the dive sample record parser: shared constants, result codes
// and the transaction payload types. No dependencies.
`timescale 1ns / 1ps

package dsrp_pkg;

    // Record length bookkeeping
    localparam int MAX_RECORD_BYTES = 4096;
    localparam int POS_W            = $clog2(MAX_RECORD_BYTES + 1);
    localparam int MIN_RECORD       = 18;
    localparam int HEADER_BASE      = 40;

    // Sample clock in seconds
    localparam logic [15:0] TIME_START = 16'd20;
    localparam logic [15:0] TIME_STEP  = 16'd20;
    localparam logic [15:0] TIME_MAX   = 16'hFFFF;

    // Model byte decode (high nibble of byte 3)
    localparam logic [7:0] NIBBLE_MASK   = 8'hF0;
    localparam logic [7:0] NITROX_NIBBLE = 8'hF0;
    localparam logic [7:0] OXYGEN_NIBBLE = 8'hA0;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_VENDOR = 2'd1,
        KIND_END_OK = 2'd2,
        KIND_END_ERR = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_rec_byte;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] time_seconds;
        logic [9:0]  depth_raw;
        logic        deco_stop;
        logic [4:0]  event_mask;
        logic        gas_change;
        logic [7:0]  vendor_first;
        logic [7:0]  vendor_second;
        logic [1:0]  vendor_count;
        logic        last;
    } t_result;

endpackage

### design/dsrp_if.sv
// Valid/ready stream interfaces for record bytes in and parse results out.
// Depends on dsrp_pkg for the payload types.
`timescale 1ns / 1ps

interface dsrp_in_if;
    logic                 valid;
    logic                 ready;
    dsrp_pkg::t_rec_byte  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dsrp_out_if;
    logic               valid;
    logic               ready;
    dsrp_pkg::t_result  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/dive_sample_record_parser_core.sv
// Dive sample record parser, top level: byte decoder and result queue.
// Depends on dsrp_pkg and the stream interfaces in dsrp_if.sv.
`timescale 1ns / 1ps

// Takes one record byte per cycle (a transaction on i_rec) and returns parse
// results on o_res. After a header of 40 bytes (42 for nitrox, 43 for oxygen
// models, from the high nibble of byte 3) the record is read as big-endian
// 16-bit sample words; every sample gives one result, and while the sample
// clock is below its maximum every third sample is followed by one vendor
// byte (two for oxygen) given as one vendor result; the byte flagged
// last_byte also gives an ok or error end result, flagged last, after which
// the parser is back in its reset state. A byte is decoded in the cycle it
// is accepted and its zero, one or two results go into a four-entry result
// queue, so a byte can be taken every cycle; i_rec.ready is low only while
// three or more results wait in that queue, i.e. when o_res is held off.
// No clearing pass is needed after reset.
module dive_sample_record_parser_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dsrp_in_if.sink       i_rec,
    dsrp_out_if.source    o_res
);
    import dsrp_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER    = 2'd0,
        PH_WORD_HIGH = 2'd1,
        PH_VENDOR    = 2'd2,
        PH_WORD_LOW  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MODEL_PLAIN  = 2'd0,
        MODEL_NITROX = 2'd1,
        MODEL_OXYGEN = 2'd2
    } t_model;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // ---------------- parser state ----------------
    logic [POS_W-1:0] r_byte_pos, n_byte_pos;
    t_model           r_model,    n_model;
    t_phase           r_phase,    n_phase;
    logic [7:0]       r_word_hi,  n_word_hi;
    logic [15:0]      r_time,     n_time;
    logic [1:0]       r_mod3,     n_mod3;
    logic             r_first,    n_first;
    logic [1:0]       r_vleft,    n_vleft;
    logic [7:0]       r_vhold,    n_vhold;

    // ---------------- result queue ----------------
    t_result           r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic             accept;
    logic             pop;
    logic [POS_W:0]   total;        // bytes seen including this one
    logic [5:0]       hdr_len;
    logic [15:0]      word;
    logic [15:0]      time_adv;
    logic [1:0]       mod3_adv;
    logic             fin;
    logic             bad;
    logic             have_main;    // sample or vendor result on this byte
    t_result          main_res;
    t_result          end_res;
    t_result          slot0, slot1;
    logic [1:0]       push_cnt;

    assign accept = i_rec.valid && i_rec.ready;
    assign pop    = o_res.valid && o_res.ready;

    // Room for the worst case of two results per byte.
    assign i_rec.ready = (r_count <= QCNT_W'(QDEPTH - 2));
    assign o_res.valid = (r_count != '0);
    assign o_res.data  = r_q[r_rd_ptr];

    assign total = {1'b0, r_byte_pos} + (POS_W+1)'(1);
    assign word  = {r_word_hi, i_rec.data.data_byte};
    assign fin   = i_rec.data.last_byte;

    always_comb begin
        case (r_model)
            MODEL_NITROX: hdr_len = 6'(HEADER_BASE + 2);
            MODEL_OXYGEN: hdr_len = 6'(HEADER_BASE + 3);
            default:      hdr_len = 6'(HEADER_BASE);
        endcase
    end

    // Saturating sample clock and the every-third-sample counter
    assign time_adv = (r_time > (TIME_MAX - TIME_STEP)) ? TIME_MAX : r_time + TIME_STEP;
    assign mod3_adv = (r_mod3 >= 2'd2) ? 2'd0 : r_mod3 + 2'd1;

    // Byte decode and next state
    always_comb begin
        n_byte_pos = r_byte_pos;
        n_model    = r_model;
        n_phase    = r_phase;
        n_word_hi  = r_word_hi;
        n_time     = r_time;
        n_mod3     = r_mod3;
        n_first    = r_first;
        n_vleft    = r_vleft;
        n_vhold    = r_vhold;
        have_main  = 1'b0;
        main_res   = '0;
        end_res    = '0;

        if (r_byte_pos < POS_W'(MAX_RECORD_BYTES)) begin
            n_byte_pos = r_byte_pos + POS_W'(1);
        end

        case (r_phase)
            PH_HEADER: begin
                if (r_byte_pos == POS_W'(3)) begin
                    if ((i_rec.data.data_byte & NIBBLE_MASK) == NITROX_NIBBLE) begin
                        n_model = MODEL_NITROX;
                    end else if ((i_rec.data.data_byte & NIBBLE_MASK) == OXYGEN_NIBBLE) begin
                        n_model = MODEL_OXYGEN;
                    end else begin
                        n_model = MODEL_PLAIN;
                    end
                end
                // byte 3 precedes the end of any header, so r_model is settled here
                if (total >= (POS_W+1)'(hdr_len)) begin
                    n_phase = PH_WORD_HIGH;
                end
            end
            PH_WORD_HIGH: begin
                n_word_hi = i_rec.data.data_byte;
                n_phase   = PH_WORD_LOW;
            end
            PH_WORD_LOW: begin
                have_main             = 1'b1;
                main_res.kind         = KIND_SAMPLE;
                main_res.time_seconds = r_time;
                main_res.depth_raw    = word[15:6];
                main_res.deco_stop    = word[0];
                main_res.event_mask   = word[5:1];
                main_res.gas_change   = r_first;
                n_first               = 1'b0;
                if (r_mod3 == 2'd2 && r_time != TIME_MAX) begin
                    n_vleft = (r_model == MODEL_OXYGEN) ? 2'd2 : 2'd1;
                    n_phase = PH_VENDOR;
                end else begin
                    n_time  = time_adv;
                    n_mod3  = mod3_adv;
                    n_phase = PH_WORD_HIGH;
                end
            end
            default: begin  // vendor bytes
                if (r_vleft >= 2'd2) begin
                    n_vhold = i_rec.data.data_byte;
                    n_vleft = 2'd1;
                end else begin
                    have_main             = 1'b1;
                    main_res.kind         = KIND_VENDOR;
                    main_res.time_seconds = r_time;
                    if (r_model == MODEL_OXYGEN) begin
                        main_res.vendor_first  = r_vhold;
                        main_res.vendor_second = i_rec.data.data_byte;
                        main_res.vendor_count  = 2'd2;
                    end else begin
                        main_res.vendor_first  = i_rec.data.data_byte;
                        main_res.vendor_count  = 2'd1;
                    end
                    n_vleft = 2'd0;
                    n_time  = time_adv;
                    n_mod3  = mod3_adv;
                    n_phase = PH_WORD_HIGH;
                end
            end
        endcase

        // Short record, or the record stops while vendor bytes are still owed
        bad          = (total < (POS_W+1)'(MIN_RECORD)) || (n_phase == PH_VENDOR);
        end_res.kind = bad ? KIND_END_ERR : KIND_END_OK;
        end_res.last = 1'b1;

        if (fin) begin
            n_byte_pos = '0;
            n_model    = MODEL_PLAIN;
            n_phase    = PH_HEADER;
            n_word_hi  = '0;
            n_time     = TIME_START;
            n_mod3     = 2'd0;
            n_first    = 1'b1;
            n_vleft    = 2'd0;
            n_vhold    = '0;
        end
    end

    // Order within a byte: sample/vendor result first, then the end result
    always_comb begin
        slot0 = have_main ? main_res : end_res;
        slot1 = end_res;
        if (!accept) begin
            push_cnt = 2'd0;
        end else begin
            push_cnt = 2'(have_main) + 2'(fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_model    <= MODEL_PLAIN;
            r_phase    <= PH_HEADER;
            r_word_hi  <= '0;
            r_time     <= TIME_START;
            r_mod3     <= 2'd0;
            r_first    <= 1'b1;
            r_vleft    <= 2'd0;
            r_vhold    <= '0;
        end else if (accept) begin
            r_byte_pos <= n_byte_pos;
            r_model    <= n_model;
            r_phase    <= n_phase;
            r_word_hi  <= n_word_hi;
            r_time     <= n_time;
            r_mod3     <= n_mod3;
            r_first    <= n_first;
            r_vleft    <= n_vleft;
            r_vhold    <= n_vhold;
        end
    end

    // Queue storage: payload only, no reset
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_q[r_wr_ptr] <= slot0;
        end
        if (push_cnt == 2'd2) begin
            r_q[r_wr_ptr + QPTR_W'(1)] <= slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(push_cnt) - QCNT_W'(pop);
        end
    end

endmodule

### design/dsrp_checker.sv
// Port-level assertions for the dive sample record parser, and the bind
// that attaches them to dive_sample_record_parser_core. Depends on dsrp_pkg.
`timescale 1ns / 1ps

module dsrp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  dsrp_pkg::t_result  i_out_data
);
    import dsrp_pkg::*;

    // A stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed while stalled");

    // Only end results close a record, and every end result does
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.last ==
            (i_out_data.kind == KIND_END_OK || i_out_data.kind == KIND_END_ERR)))
        else $error("last flag does not match end kind");

    // Vendor byte count present exactly on vendor results
    a_vendor_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_data.vendor_count != 2'd0) ==
            (i_out_data.kind == KIND_VENDOR)))
        else $error("vendor count on wrong result kind");

    // Gas change only rides on a sample
    a_gas_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.gas_change) |-> (i_out_data.kind == KIND_SAMPLE))
        else $error("gas change outside a sample");

endmodule

bind dive_sample_record_parser_core dsrp_checker u_dsrp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

### verif/dsrp_result_checker.sv
// Result checker for the dive sample record parser: watches both streams,
// predicts the results of every accepted byte and compares them in order.
// Depends on dsrp_pkg and the stream interfaces in dsrp_if.sv.
`timescale 1ns / 1ps

module dsrp_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dsrp_in_if   i_rec,
    dsrp_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_samples_seen,
    output int   o_vendor_seen,
    output int   o_ends_seen
);
    import dsrp_pkg::*;

    localparam int REPORT_CAP = 60;   // keep the log readable on a badly broken build

    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_WORD_HIGH,
        PARSE_WORD_LOW,
        PARSE_VENDOR
    } t_parse_phase;

    typedef enum logic [1:0] {
        MODEL_PLAIN,
        MODEL_NITROX,
        MODEL_OXYGEN
    } t_model;

    // parser image
    int unsigned  rec_pos;
    t_model       model;
    t_parse_phase phase;
    logic [7:0]   word_hi;
    logic [15:0]  sample_time;
    logic [1:0]   sample_mod3;
    logic         first_sample;
    logic [1:0]   vendor_left;
    logic [7:0]   vendor_hold;

    t_result      parse_results[$];
    t_result      got;
    t_result      want;
    bit           wrong;

    function automatic void restart_record();
        rec_pos      = 0;
        model        = MODEL_PLAIN;
        phase        = PARSE_HEADER;
        word_hi      = '0;
        sample_time  = TIME_START;
        sample_mod3  = '0;
        first_sample = 1'b1;
        vendor_left  = '0;
        vendor_hold  = '0;
    endfunction

    function automatic void tick_sample_clock();
        sample_time = (sample_time > TIME_MAX - TIME_STEP) ? TIME_MAX : sample_time + TIME_STEP;
        sample_mod3 = (sample_mod3 >= 2'd2) ? 2'd0 : sample_mod3 + 2'd1;
    endfunction

    task automatic parse_record_byte(input logic [7:0] b, input logic fin);
        t_result     r;
        int unsigned total;
        logic [15:0] w;
        total = rec_pos + 1;
        if (rec_pos < MAX_RECORD_BYTES)
            rec_pos++;
        case (phase)
            PARSE_HEADER: begin
                if (total == 4) begin
                    if ((b & NIBBLE_MASK) == NITROX_NIBBLE)
                        model = MODEL_NITROX;
                    else if ((b & NIBBLE_MASK) == OXYGEN_NIBBLE)
                        model = MODEL_OXYGEN;
                    else
                        model = MODEL_PLAIN;
                end
                if (total >= HEADER_BASE + ((model == MODEL_NITROX) ? 2 :
                                            (model == MODEL_OXYGEN) ? 3 : 0))
                    phase = PARSE_WORD_HIGH;
            end
            PARSE_WORD_HIGH: begin
                word_hi = b;
                phase = PARSE_WORD_LOW;
            end
            PARSE_WORD_LOW: begin
                w = {word_hi, b};
                r = '0;
                r.kind         = KIND_SAMPLE;
                r.time_seconds = sample_time;
                r.depth_raw    = w[15:6];
                r.deco_stop    = w[0];
                r.event_mask   = w[5:1];
                r.gas_change   = first_sample;
                parse_results.push_back(r);
                first_sample = 1'b0;
                if (sample_mod3 == 2'd2 && sample_time != TIME_MAX) begin
                    vendor_left = (model == MODEL_OXYGEN) ? 2'd2 : 2'd1;
                    phase = PARSE_VENDOR;
                end else begin
                    tick_sample_clock();
                    phase = PARSE_WORD_HIGH;
                end
            end
            default: begin
                if (vendor_left >= 2'd2) begin
                    vendor_hold = b;
                    vendor_left = 2'd1;
                end else begin
                    r = '0;
                    r.kind         = KIND_VENDOR;
                    r.time_seconds = sample_time;
                    if (model == MODEL_OXYGEN) begin
                        r.vendor_first  = vendor_hold;
                        r.vendor_second = b;
                        r.vendor_count  = 2'd2;
                    end else begin
                        r.vendor_first = b;
                        r.vendor_count = 2'd1;
                    end
                    parse_results.push_back(r);
                    vendor_left = '0;
                    tick_sample_clock();
                    phase = PARSE_WORD_HIGH;
                end
            end
        endcase
        if (fin) begin
            r = '0;
            r.kind = (total < MIN_RECORD || phase == PARSE_VENDOR) ? KIND_END_ERR : KIND_END_OK;
            r.last = 1'b1;
            parse_results.push_back(r);
            restart_record();
        end
    endtask

    function automatic bit field_differs(input string name, input int unsigned exp_val,
                                         input int unsigned act_val);
        if (exp_val == act_val)
            return 1'b0;
        if (o_fail_count < REPORT_CAP)
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_record();
            parse_results.delete();
        end else begin
            if (i_rec.valid && i_rec.ready)
                parse_record_byte(i_rec.data.data_byte, i_rec.data.last_byte);
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (parse_results.size() == 0) begin
                    if (o_fail_count < REPORT_CAP)
                        $error("result with nothing outstanding, kind %0d", got.kind);
                    o_fail_count++;
                end else begin
                    want = parse_results.pop_front();
                    wrong = 1'b0;
                    wrong |= field_differs("kind", want.kind, got.kind);
                    wrong |= field_differs("time_seconds", want.time_seconds, got.time_seconds);
                    wrong |= field_differs("depth_raw", want.depth_raw, got.depth_raw);
                    wrong |= field_differs("deco_stop", want.deco_stop, got.deco_stop);
                    wrong |= field_differs("event_mask", want.event_mask, got.event_mask);
                    wrong |= field_differs("gas_change", want.gas_change, got.gas_change);
                    wrong |= field_differs("vendor_first", want.vendor_first, got.vendor_first);
                    wrong |= field_differs("vendor_second", want.vendor_second,
                                           got.vendor_second);
                    wrong |= field_differs("vendor_count", want.vendor_count, got.vendor_count);
                    wrong |= field_differs("last", want.last, got.last);
                    if (wrong)
                        o_fail_count++;
                    case (want.kind)
                        KIND_SAMPLE: o_samples_seen++;
                        KIND_VENDOR: o_vendor_seen++;
                        default:     o_ends_seen++;
                    endcase
                end
            end
        end
        o_pending = parse_results.size();
    end

endmodule

### verif/dive_sample_record_parser_core_test.sv
// Testbench top for the dive sample record parser: clock, reset, record
// stimulus on i_rec, random back-pressure on o_res and the final verdict.
// Depends on dsrp_pkg, dsrp_if.sv, the core and dsrp_result_checker.
`timescale 1ns / 1ps

module dive_sample_record_parser_core_test;
    import dsrp_pkg::*;

    // CYCLE_LIMIT is a hang guard, not a performance target.
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 20;       // idle wait after all results are out
    localparam int RANDOM_BYTES = 600;

    logic i_clk;
    logic i_rst_n;

    dsrp_in_if  rec_bus ();
    dsrp_out_if res_bus ();

    int fail_count;
    int pending;
    int samples_seen;
    int vendor_seen;
    int ends_seen;

    int cycle_count = 0;
    int bytes_sent  = 0;
    int records_sent = 0;
    int stall_left  = 0;
    bit sender_idles = 1'b0;
    bit receiver_stalls = 1'b0;

    logic [7:0] record_bytes[$];

    dive_sample_record_parser_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_bus),
        .o_res   (res_bus)
    );

    dsrp_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec          (rec_bus),
        .i_res          (res_bus),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_samples_seen (samples_seen),
        .o_vendor_seen  (vendor_seen),
        .o_ends_seen    (ends_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hang guard: a stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts, changed on the falling
    // edge so the core sees a stable ready at the rising edge.
    always @(negedge i_clk) begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (receiver_stalls && $urandom_range(0, 7) == 0)
            stall_left <= $urandom_range(1, 11);
    end

    assign res_bus.ready = (stall_left == 0);

    // One byte transaction. Entered and left on a falling edge; valid stays
    // high across back-to-back bytes, so it is never dropped and raised in
    // the same time step.
    task automatic send_transaction(input logic [7:0] b, input logic fin);
        if (sender_idles && $urandom_range(0, 7) == 0) begin
            rec_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        rec_bus.valid          <= 1'b1;
        rec_bus.data.data_byte <= b;
        rec_bus.data.last_byte <= fin;
        @(posedge i_clk);
        while (!rec_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Lays out a well-formed record: header of the length the model byte
    // selects, then sample words with vendor bytes after every third sample
    // for as long as the sample clock has not saturated. Content is random.
    task automatic build_record(input logic [7:0] model_byte, input int n_samples);
        int header_len;
        int vendor_len;
        header_len = HEADER_BASE;
        vendor_len = 1;
        if ((model_byte & NIBBLE_MASK) == NITROX_NIBBLE) begin
            header_len = HEADER_BASE + 2;
        end else if ((model_byte & NIBBLE_MASK) == OXYGEN_NIBBLE) begin
            header_len = HEADER_BASE + 3;
            vendor_len = 2;
        end
        record_bytes.delete();
        for (int i = 0; i < header_len; i++)
            record_bytes.push_back(8'($urandom_range(0, 255)));
        record_bytes[3] = model_byte;
        for (int s = 1; s <= n_samples; s++) begin
            record_bytes.push_back(8'($urandom_range(0, 255)));
            record_bytes.push_back(8'($urandom_range(0, 255)));
            if (s % 3 == 0 && int'(TIME_STEP) * s <= int'(TIME_MAX))
                repeat (vendor_len) record_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Sends the first 'length' bytes of the built record, flagging the final
    // one as the end of the record.
    task automatic send_record(input int length);
        int n;
        n = (length > record_bytes.size()) ? record_bytes.size() : length;
        if (n < 1)
            n = 1;
        for (int i = 0; i < n; i++)
            send_transaction(record_bytes[i], i == n - 1);
        records_sent++;
    endtask

    initial begin
        int         random_start;
        int         shape;
        logic [7:0] model_byte;

        rec_bus.valid = 1'b0;
        rec_bus.data  = '0;
        i_rst_n       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        sender_idles = 1'b1;
        receiver_stalls <= 1'b1;

        // ---- Directed part ----
        // Short records: a lone final byte, and one byte under the minimum.
        build_record(8'h00, 0);
        send_record(1);
        send_record(17);
        // Header-only records: exactly the minimum, and a full plain header.
        send_record(MIN_RECORD);
        send_record(HEADER_BASE);

        // Plain record with extreme sample words; the last byte closes a
        // sample, so sample and end arrive together.
        build_record(8'h5C, 4);
        record_bytes[40] = 8'h00;  record_bytes[41] = 8'h00;  // all clear
        record_bytes[42] = 8'hFF;  record_bytes[43] = 8'hFF;  // all set
        record_bytes[44] = 8'hFF;  record_bytes[45] = 8'hC0;  // deepest, no flags
        record_bytes[46] = 8'hFF;                             // vendor byte
        record_bytes[47] = 8'h00;  record_bytes[48] = 8'h3F;  // every event, deco stop
        send_record(record_bytes.size());

        // Nitrox record ending on its vendor byte: vendor result then end.
        build_record(8'hF3, 3);
        send_record(record_bytes.size());

        // Oxygen record with extreme vendor pair and a sample after it.
        build_record(8'hA7, 4);
        record_bytes[49] = 8'h00;
        record_bytes[50] = 8'hFF;
        send_record(record_bytes.size());

        // Record ending inside the vendor bytes: second oxygen byte missing,
        // then a sample on the final byte that still owes its vendor bytes.
        build_record(8'hAF, 3);
        send_record(record_bytes.size() - 1);
        send_record(record_bytes.size() - 2);
        build_record(8'h00, 3);
        send_record(record_bytes.size() - 1);

        // Odd trailing byte after the last complete sample.
        build_record(8'h12, 2);
        record_bytes.push_back(8'($urandom_range(0, 255)));
        send_record(record_bytes.size());

        // Model bytes just beside the nitrox and oxygen nibbles decode as plain.
        build_record(8'hEF, 1);
        send_record(record_bytes.size());
        build_record(8'hB0, 1);
        send_record(record_bytes.size());

        // Hold off until everything owed so far has come out.
        rec_bus.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);

        // ---- Random part ----
        // Mostly well-formed records with random content and length; the rest
        // are cut short, near the minimum length, or plain noise. Idling
        // is switched per record and dropped for the final fifth.
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if (bytes_sent - random_start > RANDOM_BYTES * 4 / 5) begin
                sender_idles = 1'b0;
                receiver_stalls <= 1'b0;
            end else begin
                sender_idles = ($urandom_range(0, 2) != 0);
                receiver_stalls <= ($urandom_range(0, 2) != 0);
            end

            model_byte = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0: model_byte = (model_byte & ~NIBBLE_MASK) | NITROX_NIBBLE;
                1: model_byte = (model_byte & ~NIBBLE_MASK) | OXYGEN_NIBBLE;
                2: model_byte[7:4] = 4'($urandom_range(0, 9));
                default: ;
            endcase
            build_record(model_byte, $urandom_range(0, 16));

            shape = $urandom_range(0, 99);
            if (shape < 70) begin
                if ($urandom_range(0, 3) == 0)
                    record_bytes.push_back(8'($urandom_range(0, 255)));
                send_record(record_bytes.size());
            end else if (shape < 85) begin
                send_record($urandom_range(1, record_bytes.size()));
            end else if (shape < 95) begin
                send_record($urandom_range(1, 20));
            end else begin
                record_bytes.delete();
                repeat ($urandom_range(1, 64))
                    record_bytes.push_back(8'($urandom_range(0, 255)));
                send_record(record_bytes.size());
            end

            if ($urandom_range(0, 9) == 0) begin
                rec_bus.valid <= 1'b0;
                while (pending != 0)
                    @(negedge i_clk);
            end
        end

        rec_bus.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d records (%0d byte transactions): short, header-only, cut, noisy.",
                 records_sent, bytes_sent);
        $display("Checked %0d sample, %0d vendor and %0d end results.",
                 samples_seen, vendor_seen, ends_seen);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
